@@ hdl/acex_pkg.sv @@
// Package: shared types and constants for the accumulator CPU execute block.
package acex_pkg;

    localparam int ADDR_BITS_DEF = 16;
    localparam int MEM_ADDR_W    = 16;

    localparam logic [2:0] RC_M = 3'b110;
    localparam logic [2:0] RC_A = 3'b111;

    typedef enum logic [3:0] {
        K_LOAD,
        K_NOP,
        K_HLT,
        K_MOV,
        K_ALU,
        K_INCDEC,
        K_LDAX,
        K_STAX,
        K_PUSH,
        K_POP,
        K_MISC,
        K_ILLEGAL
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  opcode;
        logic [15:0] load_address;
        logic [7:0]  load_data;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_FETCH,
        ST_SECOND,
        ST_SHOW
    } exec_state_t;

    function automatic logic parity_even(input logic [7:0] v);
        return ~(^v);
    endfunction

endpackage

@@ hdl/acex_front.sv @@
// Front end: accepts input words, classifies opcodes and queues them.
module acex_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              stall,
    input  logic              command,
    input  logic [7:0]        opcode,
    input  logic [15:0]       load_address,
    input  logic [7:0]        load_data,
    output logic              q_valid,
    input  logic              q_take,
    output acex_pkg::cmd_t    q_cmd
);

    acex_pkg::cmd_t       fifo_reg [2];
    logic                 wp_reg;
    logic                 rp_reg;
    logic [1:0]           cnt_reg;
    acex_pkg::kind_t      kind;
    acex_pkg::cmd_t       item;
    logic                 push;
    logic                 pop;

    always_comb
    begin
        if (command)
            kind = acex_pkg::K_LOAD;
        else if (opcode == 8'h76)
            kind = acex_pkg::K_HLT;
        else if (opcode[7:6] == 2'b01)
            kind = acex_pkg::K_MOV;
        else if (opcode[7:6] == 2'b10)
            kind = acex_pkg::K_ALU;
        else if ((opcode & 8'hC6) == 8'h04)
            kind = acex_pkg::K_INCDEC;
        else if ((opcode & 8'hEF) == 8'h0A)
            kind = acex_pkg::K_LDAX;
        else if ((opcode & 8'hEF) == 8'h02)
            kind = acex_pkg::K_STAX;
        else if ((opcode & 8'hCF) == 8'hC5)
            kind = acex_pkg::K_PUSH;
        else if ((opcode & 8'hCF) == 8'hC1)
            kind = acex_pkg::K_POP;
        else if (opcode == 8'h00)
            kind = acex_pkg::K_NOP;
        else if (opcode == 8'h07 || opcode == 8'h0F || opcode == 8'h17 || opcode == 8'h1F ||
                 opcode == 8'h2F || opcode == 8'h37 || opcode == 8'h3F)
            kind = acex_pkg::K_MISC;
        else
            kind = acex_pkg::K_ILLEGAL;
        item = '{kind: kind, opcode: opcode, load_address: load_address,
                 load_data: load_data};
    end

    assign stall   = (cnt_reg == 2'd2);
    assign push    = valid && !stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_take;
    assign q_cmd   = fifo_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wp_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ hdl/acex_back.sv @@
// Back end: executes queued words against registers, flags, stack and memory.
module acex_back #(
    parameter int ADDR_BITS = acex_pkg::ADDR_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_take,
    input  acex_pkg::cmd_t    q_cmd,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        reg_a,
    output logic [7:0]        reg_b,
    output logic [7:0]        reg_c,
    output logic [7:0]        reg_d,
    output logic [7:0]        reg_e,
    output logic [7:0]        reg_h,
    output logic [7:0]        reg_l,
    output logic [7:0]        status_word,
    output logic [15:0]       stack_pointer,
    output logic              halted,
    output logic              illegal_opcode
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rdata_reg;

    // register file indexed B C D E H L A
    logic [7:0]  gr_reg [7];
    logic [7:0]  gr_next [7];
    logic [4:0]  fl_reg, fl_next;
    logic [15:0] sp_reg, sp_next;
    logic        halt_reg, halt_next;
    acex_pkg::exec_state_t st_reg, st_next;
    logic [7:0]  lo_reg, lo_next;

    logic [7:0]  o_gr [7];
    logic [7:0]  o_sw;
    logic [15:0] o_sp;
    logic        o_halt, o_ill, ov_reg;
    logic        out_load;

    logic              mem_we;
    logic [ADDR_BITS-1:0] mem_wa, mem_ra;
    logic [7:0]        mem_wd;
    logic              ill;

    logic [7:0] opc;
    logic [2:0] rd, rs, alu;
    logic [1:0] rp;
    logic [15:0] hl;
    logic [7:0]  a;
    logic [15:0] rp_addr;
    logic [15:0] ra_full;

    function automatic logic [2:0] idx(input logic [2:0] code);
        return (code == acex_pkg::RC_A) ? 3'd6 : code;
    endfunction

    function automatic logic [7:0] sbyte(input logic [4:0] f);
        return {f[4], f[3], 1'b0, f[2], 1'b0, f[1], 1'b1, f[0]};
    endfunction

    function automatic logic [2:0] szp(input logic [7:0] v);
        return {v[7], v == 8'd0, acex_pkg::parity_even(v)};
    endfunction

    function automatic logic [ADDR_BITS-1:0] sp_next_m1(input logic [15:0] s);
        logic [15:0] t;
        t = s - 16'd1;
        return t[ADDR_BITS-1:0];
    endfunction

    function automatic logic [ADDR_BITS-1:0] sp_next_m2(input logic [15:0] s);
        logic [15:0] t;
        t = s - 16'd2;
        return t[ADDR_BITS-1:0];
    endfunction

    assign opc = q_cmd.opcode;
    assign rd  = opc[5:3];
    assign rs  = opc[2:0];
    assign alu = opc[5:3];
    assign rp  = opc[5:4];
    assign hl  = {gr_reg[4], gr_reg[5]};
    assign a   = gr_reg[6];
    assign rp_addr = {gr_reg[{rp, 1'b0}], gr_reg[{rp, 1'b1}]};

    // whether the word needs a memory read first
    logic need_rd;
    always_comb
    begin
        need_rd = 1'b0;
        ra_full = hl;
        case (q_cmd.kind)
            acex_pkg::K_MOV:    need_rd = (rs == acex_pkg::RC_M);
            acex_pkg::K_ALU:    need_rd = (rs == acex_pkg::RC_M);
            acex_pkg::K_INCDEC: need_rd = (rd == acex_pkg::RC_M);
            acex_pkg::K_LDAX:
            begin
                need_rd = 1'b1;
                ra_full = rp_addr;
            end
            acex_pkg::K_POP:
            begin
                need_rd = 1'b1;
                ra_full = (st_reg == acex_pkg::ST_FETCH) ? sp_reg : sp_reg + 16'd1;
            end
            default: need_rd = 1'b0;
        endcase
        if (halt_reg && q_cmd.kind != acex_pkg::K_LOAD)
            need_rd = 1'b0;
    end

    assign mem_ra = ra_full[ADDR_BITS-1:0];

    logic [7:0] src, x, res, sum_v;
    logic [8:0] sum9;
    logic [4:0] lsum;
    logic       cin, acf, cyf, sub;
    logic [7:0] bop;
    logic       done;
    logic [2:0] fz;

    always_comb
    begin
        for (int i = 0; i < 7; i++)
            gr_next[i] = gr_reg[i];
        fl_next   = fl_reg;
        sp_next   = sp_reg;
        halt_next = halt_reg;
        st_next   = st_reg;
        lo_next   = lo_reg;
        mem_we    = 1'b0;
        mem_wa    = hl[ADDR_BITS-1:0];
        mem_wd    = 8'd0;
        ill       = 1'b0;
        q_take    = 1'b0;
        done      = 1'b0;
        src = (rs == acex_pkg::RC_M) ? rdata_reg : gr_reg[idx(rs)];
        x   = (rd == acex_pkg::RC_M) ? rdata_reg : gr_reg[idx(rd)];
        sub = (alu == 3'd2) || (alu == 3'd3) || (alu == 3'd7);
        bop = sub ? ~src : src;
        cin = (alu == 3'd1) ? fl_reg[0] : (alu == 3'd3) ? ~fl_reg[0] : sub;
        sum9 = {1'b0, a} + {1'b0, bop} + {8'd0, cin};
        lsum = {1'b0, a[3:0]} + {1'b0, bop[3:0]} + {4'd0, cin};
        res = 8'd0;
        acf = 1'b0;
        cyf = 1'b0;
        sum_v = 8'd0;
        fz = 3'd0;
        unique case (st_reg)
            acex_pkg::ST_FETCH, acex_pkg::ST_SECOND:
            begin
                if (q_valid && !(ov_reg && out_stall))
                begin
                    if (need_rd && st_reg == acex_pkg::ST_FETCH)
                        st_next = acex_pkg::ST_SECOND;
                    else if (q_cmd.kind == acex_pkg::K_POP && !halt_reg &&
                             st_reg == acex_pkg::ST_SECOND && lo_reg == 8'd0 && 1'b0)
                        st_next = st_reg;
                    else
                        done = 1'b1;
                end
            end
            acex_pkg::ST_SHOW:
            begin
                // final step of POP and second byte write of PUSH
                if (!(ov_reg && out_stall))
                    done = 1'b1;
            end
            default: st_next = acex_pkg::ST_FETCH;
        endcase
        if (done)
        begin
            st_next = acex_pkg::ST_FETCH;
            q_take  = 1'b1;
            if (q_cmd.kind == acex_pkg::K_LOAD)
            begin
                mem_we = 1'b1;
                mem_wa = q_cmd.load_address[ADDR_BITS-1:0];
                mem_wd = q_cmd.load_data;
            end
            else if (!halt_reg)
            begin
                case (q_cmd.kind)
                    acex_pkg::K_HLT: halt_next = 1'b1;
                    acex_pkg::K_MOV:
                    begin
                        if (rd == acex_pkg::RC_M)
                        begin
                            mem_we = 1'b1;
                            mem_wd = src;
                        end
                        else
                            gr_next[idx(rd)] = src;
                    end
                    acex_pkg::K_ALU:
                    begin
                        case (alu)
                            3'd4:
                            begin
                                res = a & src;
                                acf = a[3] | src[3];
                            end
                            3'd5: res = a ^ src;
                            3'd6: res = a | src;
                            default:
                            begin
                                res = sum9[7:0];
                                acf = lsum[4];
                                cyf = sub ? ~sum9[8] : sum9[8];
                            end
                        endcase
                        fz = szp(res);
                        fl_next = {fz[2:1], acf, fz[0], cyf};
                        if (alu != 3'd7)
                            gr_next[6] = res;
                    end
                    acex_pkg::K_INCDEC:
                    begin
                        if (opc[0])
                        begin
                            sum_v = x - 8'd1;
                            acf = (x[3:0] != 4'h0);
                        end
                        else
                        begin
                            sum_v = x + 8'd1;
                            acf = (x[3:0] == 4'hF);
                        end
                        fz = szp(sum_v);
                        fl_next = {fz[2:1], acf, fz[0], fl_reg[0]};
                        if (rd == acex_pkg::RC_M)
                        begin
                            mem_we = 1'b1;
                            mem_wd = sum_v;
                        end
                        else
                            gr_next[idx(rd)] = sum_v;
                    end
                    acex_pkg::K_LDAX: gr_next[6] = rdata_reg;
                    acex_pkg::K_STAX:
                    begin
                        mem_we = 1'b1;
                        mem_wa = rp_addr[ADDR_BITS-1:0];
                        mem_wd = a;
                    end
                    acex_pkg::K_PUSH:
                    begin
                        if (st_reg == acex_pkg::ST_FETCH)
                        begin
                            // first byte: high part
                            q_take  = 1'b0;
                            st_next = acex_pkg::ST_SHOW;
                            mem_we  = 1'b1;
                            mem_wa  = sp_next_m1(sp_reg);
                            mem_wd  = (rp == 2'd3) ? a : gr_reg[{rp, 1'b0}];
                        end
                        else
                        begin
                            mem_we  = 1'b1;
                            mem_wa  = sp_next_m2(sp_reg);
                            mem_wd  = (rp == 2'd3) ? sbyte(fl_reg) : gr_reg[{rp, 1'b1}];
                            sp_next = sp_reg - 16'd2;
                        end
                    end
                    acex_pkg::K_POP:
                    begin
                        if (st_reg == acex_pkg::ST_SECOND)
                        begin
                            q_take  = 1'b0;
                            st_next = acex_pkg::ST_SHOW;
                            lo_next = rdata_reg;
                        end
                        else
                        begin
                            sp_next = sp_reg + 16'd2;
                            if (rp == 2'd3)
                            begin
                                gr_next[6] = rdata_reg;
                                fl_next = {lo_reg[7], lo_reg[6], lo_reg[4], lo_reg[2],
                                           lo_reg[0]};
                            end
                            else
                            begin
                                gr_next[{rp, 1'b0}] = rdata_reg;
                                gr_next[{rp, 1'b1}] = lo_reg;
                            end
                        end
                    end
                    acex_pkg::K_MISC:
                    begin
                        case (opc)
                            8'h07:
                            begin
                                gr_next[6] = {a[6:0], a[7]};
                                fl_next[0] = a[7];
                            end
                            8'h0F:
                            begin
                                gr_next[6] = {a[0], a[7:1]};
                                fl_next[0] = a[0];
                            end
                            8'h17:
                            begin
                                gr_next[6] = {a[6:0], fl_reg[0]};
                                fl_next[0] = a[7];
                            end
                            8'h1F:
                            begin
                                gr_next[6] = {fl_reg[0], a[7:1]};
                                fl_next[0] = a[0];
                            end
                            8'h2F: gr_next[6] = ~a;
                            8'h37: fl_next[0] = 1'b1;
                            default: fl_next[0] = ~fl_reg[0];
                        endcase
                    end
                    acex_pkg::K_ILLEGAL: ill = 1'b1;
                    default: ;
                endcase
            end
        end
    end

    assign out_load = q_take;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rdata_reg <= mem[mem_ra];
        lo_reg <= lo_next;
        if (out_load)
        begin
            for (int i = 0; i < 7; i++)
                o_gr[i] <= gr_next[i];
            o_sw   <= sbyte(fl_next);
            o_sp   <= sp_next;
            o_halt <= halt_next;
            o_ill  <= ill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
                gr_reg[i] <= 8'd0;
            fl_reg   <= 5'd0;
            sp_reg   <= 16'd0;
            halt_reg <= 1'b0;
            st_reg   <= acex_pkg::ST_FETCH;
            ov_reg   <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 7; i++)
                gr_reg[i] <= gr_next[i];
            fl_reg   <= fl_next;
            sp_reg   <= sp_next;
            halt_reg <= halt_next;
            st_reg   <= st_next;
            if (out_load)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid      = ov_reg;
    assign reg_b          = o_gr[0];
    assign reg_c          = o_gr[1];
    assign reg_d          = o_gr[2];
    assign reg_e          = o_gr[3];
    assign reg_h          = o_gr[4];
    assign reg_l          = o_gr[5];
    assign reg_a          = o_gr[6];
    assign status_word    = o_sw;
    assign stack_pointer  = o_sp;
    assign halted         = o_halt;
    assign illegal_opcode = o_ill;

endmodule

@@ hdl/accumulator_cpu_exec.sv @@
// Top level: 8080 execute subset with a decoupled front end and execute back end.
// One word in, one result word out with the full register state after it. Words that
// read one memory byte pass through states FETCH and SECOND (the memory read is
// registered); PUSH does its two byte writes in FETCH and SHOW, and POP its two reads
// in FETCH, SECOND and SHOW; every other word, memory writes and loads included,
// completes in FETCH. A two-entry queue separates decode from execution and a result
// register holds the last result until it is taken.
module accumulator_cpu_exec #(
    parameter int ADDR_BITS = acex_pkg::ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [7:0]  opcode,
    input  logic [15:0] load_address,
    input  logic [7:0]  load_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  reg_a,
    output logic [7:0]  reg_b,
    output logic [7:0]  reg_c,
    output logic [7:0]  reg_d,
    output logic [7:0]  reg_e,
    output logic [7:0]  reg_h,
    output logic [7:0]  reg_l,
    output logic [7:0]  status_word,
    output logic [15:0] stack_pointer,
    output logic        halted,
    output logic        illegal_opcode
);

    logic           q_valid;
    logic           q_take;
    acex_pkg::cmd_t q_cmd;

    acex_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .command(command), .opcode(opcode), .load_address(load_address),
        .load_data(load_data), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
    );

    acex_back #(.ADDR_BITS(ADDR_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd),
        .out_valid(out_valid), .out_stall(out_stall),
        .reg_a(reg_a), .reg_b(reg_b), .reg_c(reg_c), .reg_d(reg_d), .reg_e(reg_e),
        .reg_h(reg_h), .reg_l(reg_l), .status_word(status_word),
        .stack_pointer(stack_pointer), .halted(halted), .illegal_opcode(illegal_opcode)
    );

endmodule
